// ----- rtl/lpm_pkg.sv -----
// shared types, codes and widths for the link presence monitor
`default_nettype none

package lpm_pkg;

    localparam int TimeW = 48;
    localparam int CfgW  = 24;
    localparam int CodeW = 2;
    localparam int IdxW  = 2;

    localparam logic [CodeW-1:0] LINK_AWAKE = 2'd0;
    localparam logic [CodeW-1:0] LINK_DARK  = 2'd1;
    localparam logic [CodeW-1:0] LINK_NOSIG = 2'd2;

    localparam logic [CodeW-1:0] FRESH_LIVE = 2'd0;
    localparam logic [CodeW-1:0] FRESH_IDLE = 2'd1;
    localparam logic [CodeW-1:0] FRESH_GONE = 2'd2;

    localparam logic [IdxW-1:0] REG_LIVE       = 2'd0;
    localparam logic [IdxW-1:0] REG_LOST       = 2'd1;
    localparam logic [IdxW-1:0] REG_DARK       = 2'd2;
    localparam logic [IdxW-1:0] REG_ACTIVE_GAP = 2'd3;

    localparam logic [CfgW-1:0] LIVE_RESET       = 24'd5000;
    localparam logic [CfgW-1:0] LOST_RESET       = 24'd90000;
    localparam logic [CfgW-1:0] DARK_RESET       = 24'd30000;
    localparam logic [CfgW-1:0] ACTIVE_GAP_RESET = 24'd3000;

    typedef struct packed {
        logic [CfgW-1:0] live_ms;
        logic [CfgW-1:0] lost_ms;
        logic [CfgW-1:0] dark_ms;
        logic [CfgW-1:0] gap_limit_ms;
    } lpm_cfg_t;

    typedef struct packed {
        logic              heard_any;
        logic [TimeW-1:0]  last_receive_time;
        logic [TimeW-1:0]  last_active_time;
        logic [CodeW-1:0]  reported_link;
        logic [CodeW-1:0]  reported_freshness;
        logic              reported_valid;
    } lpm_state_t;

    typedef struct packed {
        logic              produce;
        logic [CodeW-1:0]  link;
        logic [CodeW-1:0]  freshness;
        logic              changed;
    } lpm_result_t;

endpackage

`default_nettype wire

// ----- rtl/link_presence_monitor.sv -----
// link presence monitor top level: input register, evaluation, result register
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per request: func is 0
//   for a periodic tick and 1 for a packet arrival, now_ms its millisecond time.
//   Output channel (out_valid/out_ready) carries link, freshness and changed.
//   Every packet gives one result; a tick gives one only when link or
//   freshness differs from the last report.
//   A request passes from the input register through the combinational evaluation
//   to the result register. Throughput: one request per cycle while no result
//   stalls, set by the single input register. A stalled result (out_valid high,
//   out_ready low) holds the evaluation; one more request waits in the input
//   register, after which in_ready drops. Thresholds are written by the user through
//   cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
//   Reset (rst_n low, asynchronous) empties both registers, restores the
//   default thresholds and clears all history: nothing heard, nothing reported.
`default_nettype none

module link_presence_monitor
    import lpm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             func,
    input  wire logic [TimeW-1:0] now_ms,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [CodeW-1:0]      link,
    output logic [CodeW-1:0]      freshness,
    output logic                  changed,
    input  wire logic             cfg_we,
    input  wire logic [IdxW-1:0]  cfg_index,
    input  wire logic [CfgW-1:0]  cfg_data
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic             in_func_reg;
    logic [TimeW-1:0] in_now_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CodeW-1:0] out_link_reg;
    logic [CodeW-1:0] out_fresh_reg;
    logic             out_changed_reg;
    lpm_cfg_t         cfg_reg;
    lpm_cfg_t         cfg_next;
    lpm_state_t       state_reg;
    lpm_state_t       state_next;
    lpm_state_t       eval_state;
    lpm_result_t      eval_result;
    logic             fire;
    logic             take;

    lpm_eval u_eval (
        .func       (in_func_reg),
        .now_ms     (in_now_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .result     (eval_result),
        .state_next (eval_state)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;
    assign take     = in_valid && in_ready;

    assign in_valid_next  = take || (in_valid_reg && !fire);
    assign out_valid_next = fire ? eval_result.produce : (out_valid_reg && !out_ready);
    assign state_next     = fire ? eval_state : state_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LIVE:       cfg_next.live_ms      = cfg_data;
                REG_LOST:       cfg_next.lost_ms      = cfg_data;
                REG_DARK:       cfg_next.dark_ms      = cfg_data;
                REG_ACTIVE_GAP: cfg_next.gap_limit_ms = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            cfg_reg.live_ms      <= LIVE_RESET;
            cfg_reg.lost_ms      <= LOST_RESET;
            cfg_reg.dark_ms      <= DARK_RESET;
            cfg_reg.gap_limit_ms <= ACTIVE_GAP_RESET;
            state_reg            <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_func_reg <= func;
            in_now_reg  <= now_ms;
        end
        if (fire)
        begin
            out_link_reg    <= eval_result.link;
            out_fresh_reg   <= eval_result.freshness;
            out_changed_reg <= eval_result.changed;
        end
    end

    assign out_valid = out_valid_reg;
    assign link      = out_link_reg;
    assign freshness = out_fresh_reg;
    assign changed   = out_changed_reg;

endmodule

`default_nettype wire

// ----- rtl/lpm_eval.sv -----
// per-request evaluation: activity refresh, freshness, link state and report decision
`default_nettype none

module lpm_eval
    import lpm_pkg::*;
(
    input  wire logic             func,
    input  wire logic [TimeW-1:0] now_ms,
    input  wire lpm_cfg_t         cfg,
    input  wire lpm_state_t       state,
    output lpm_result_t           result,
    output lpm_state_t            state_next
);

    localparam int DiffW = TimeW + 1;
    localparam int PadW  = DiffW - CfgW;

    logic signed [DiffW-1:0] gap;
    logic signed [DiffW-1:0] act_raw;
    logic signed [DiffW-1:0] rx_age;
    logic signed [DiffW-1:0] act_age;
    logic signed [DiffW-1:0] live_thr;
    logic signed [DiffW-1:0] lost_thr;
    logic signed [DiffW-1:0] dark_thr;
    logic signed [DiffW-1:0] gap_thr;
    logic                    refresh;
    logic                    heard_next;
    logic [CodeW-1:0]        link_v;
    logic [CodeW-1:0]        fresh_v;
    logic                    changed_v;
    logic                    produce_v;

    assign live_thr = $signed({{PadW{1'b0}}, cfg.live_ms});
    assign lost_thr = $signed({{PadW{1'b0}}, cfg.lost_ms});
    assign dark_thr = $signed({{PadW{1'b0}}, cfg.dark_ms});
    assign gap_thr  = $signed({{PadW{1'b0}}, cfg.gap_limit_ms});

    // signed differences so that time running backwards reads as negative
    assign gap     = $signed({1'b0, now_ms}) - $signed({1'b0, state.last_receive_time});
    assign act_raw = $signed({1'b0, now_ms}) - $signed({1'b0, state.last_active_time});

    assign refresh = func && (!state.heard_any || (state.reported_freshness == FRESH_GONE)
                              || (gap <= gap_thr));

    assign rx_age     = func ? '0 : gap;
    assign act_age    = refresh ? '0 : act_raw;
    assign heard_next = state.heard_any | func;

    always_comb
    begin
        if (!heard_next)
        begin
            fresh_v = FRESH_GONE;
        end
        else if (rx_age < live_thr)
        begin
            fresh_v = FRESH_LIVE;
        end
        else if (rx_age < lost_thr)
        begin
            fresh_v = FRESH_IDLE;
        end
        else
        begin
            fresh_v = FRESH_GONE;
        end

        if (fresh_v == FRESH_GONE)
        begin
            link_v = LINK_NOSIG;
        end
        else if (act_age >= dark_thr)
        begin
            link_v = LINK_DARK;
        end
        else
        begin
            link_v = LINK_AWAKE;
        end
    end

    assign changed_v = !state.reported_valid || (link_v != state.reported_link)
                       || (fresh_v != state.reported_freshness);
    assign produce_v = changed_v | func;

    assign result.produce   = produce_v;
    assign result.link      = link_v;
    assign result.freshness = fresh_v;
    assign result.changed   = changed_v;

    always_comb
    begin
        state_next                   = state;
        state_next.heard_any         = heard_next;
        if (func)
        begin
            state_next.last_receive_time = now_ms;
        end
        if (refresh)
        begin
            state_next.last_active_time = now_ms;
        end
        if (produce_v)
        begin
            state_next.reported_link      = link_v;
            state_next.reported_freshness = fresh_v;
            state_next.reported_valid     = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lpm_checker.sv -----
// port-level checks for the link presence monitor, bound to the top level
`default_nettype none

module lpm_checker
    import lpm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_ready,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic [CodeW-1:0] link,
    input  wire logic [CodeW-1:0] freshness,
    input  wire logic             changed
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(link) && $stable(freshness)
                                    && $stable(changed))
        else $error("stalled result changed");

    // lost freshness always reports no signal
    a_lost_nosig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (freshness == FRESH_GONE) |-> (link == LINK_NOSIG))
        else $error("lost freshness without no-signal link");

    // no signal is reported only when freshness is lost
    a_nosig_lost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (link == LINK_NOSIG) |-> (freshness == FRESH_GONE))
        else $error("no-signal link with freshness not lost");

    // a free result side never blocks a request
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("request blocked with result side free");

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present after reset");

endmodule

bind link_presence_monitor lpm_checker u_lpm_checker (.*);

`default_nettype wire
